FILE: design/assert_macros.svh
// Assertion macros shared by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define DPF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define DPF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: design/dpf_pkg.sv
// Types, constants and the CRC-32 byte step for the DATA frame builder.
`timescale 1ns / 1ps

package dpf_pkg;

   // Largest payload a frame may announce.
   localparam logic [10:0] MAX_PAYLOAD = 11'd512;

   // Reflected CRC-32 constants.
   localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;

   // Function codes of an input item.
   localparam logic FUNC_START   = 1'b0;
   localparam logic FUNC_PAYLOAD = 1'b1;

   typedef struct packed {
      logic       func;
      logic [4:0] window;
      logic [9:0] payload_length;
      logic [7:0] sequence_number;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       end_of_frame;
      logic       last_of_run;
   } rsp_type;

   // Fold one byte into a reflected CRC-32 register, one bit per step.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: design/data_packet_framer_crc32.sv
// DATA frame builder: 12-byte header with CRC-32, payload echo and payload CRC-32.
//
// The req channel takes one item per handshake. A start item (func 0) opens a frame
// and produces 12 header bytes, or 16 when the length is zero (the empty payload CRC
// follows at once). A payload item (func 1) produces its byte, and the last payload
// byte of a frame also produces the four payload CRC bytes, the final one marked
// end_of_frame. Payload items with no open frame are accepted and produce nothing.
// The rsp channel carries one frame byte per item; last_of_run marks the final byte
// caused by one req item.
// The first byte of an item is registered in the engine, then in the rsp register.
// Throughput: while the rsp register is free, the engine hands it one byte per
// cycle; an item holds the engine until all its bytes have moved: 1 for a payload byte,
// 5 for the last payload byte, 12 or 16 for a start. The next item is accepted in the
// cycle the current one moves its last byte, so payload bytes flow one per cycle.
// Reset (synchronous) empties the engine and the rsp register, closes any frame and
// presets the payload CRC. When rsp_ready is low the rsp register holds its byte,
// the engine waits, and req_ready falls once the engine has an item in flight.
`timescale 1ns / 1ps

module data_packet_framer_crc32 (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dpf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dpf_pkg::rsp_type rsp_data
);

   // Kind of run held by the emission engine.
   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // Index of the final byte of each kind of run.
   localparam logic [3:0] LAST_HEADER       = 4'd11;
   localparam logic [3:0] LAST_HEADER_EMPTY = 4'd15;
   localparam logic [3:0] LAST_PAYLOAD      = 4'd0;
   localparam logic [3:0] LAST_PAYLOAD_CRC  = 4'd4;

   // Frame state.
   logic [31:0] payload_crc_ff, payload_crc_in;
   logic [9:0]  remaining_ff, remaining_in;
   logic        frame_open_ff, frame_open_in;

   // Emission engine.
   logic            busy_ff, busy_in;
   logic            kind_ff, kind_in;
   logic [3:0]      idx_ff, idx_in;
   logic [3:0]      last_ff, last_in;
   logic            close_ff, close_in;
   logic [3:0][7:0] hdr_ff, hdr_in;
   logic [31:0]     crc_ff, crc_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   dpf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic        out_free, advance, run_done, accept;
   logic [9:0]  len_sat;
   logic [31:0] byte_crc;
   logic [9:0]  rem_dec;
   logic        payload_ok;
   logic [31:0] crc_inv;
   logic [7:0]  eng_byte;

   // Handshake and per-item values.
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_ready;
      advance    = busy_ff && out_free;
      run_done   = advance && (idx_ff == last_ff);
      req_ready  = !busy_ff || run_done;
      accept     = req_valid && req_ready;
      if ({1'b0, req_data.payload_length} > dpf_pkg::MAX_PAYLOAD) begin
         len_sat = dpf_pkg::MAX_PAYLOAD[9:0];
      end else begin
         len_sat = req_data.payload_length;
      end
      byte_crc   = dpf_pkg::crc32_byte(payload_crc_ff, req_data.data_byte);
      rem_dec    = remaining_ff - 10'd1;
      payload_ok = frame_open_ff && (remaining_ff != 10'd0);
   end

   // Byte the engine emits at its current index.
   always_comb begin
      crc_inv = ~crc_ff;
      if (kind_ff == KIND_HEADER) begin
         case (idx_ff) inside
            4'd0, 4'd1, 4'd2, 4'd3: eng_byte = hdr_ff[idx_ff[1:0]];
            4'd8:    eng_byte = crc_inv[31:24];
            4'd9:    eng_byte = crc_inv[23:16];
            4'd10:   eng_byte = crc_inv[15:8];
            4'd11:   eng_byte = crc_inv[7:0];
            default: eng_byte = 8'h00;
         endcase
      end else begin
         case (idx_ff)
            4'd0:    eng_byte = hdr_ff[0];
            4'd1:    eng_byte = crc_inv[31:24];
            4'd2:    eng_byte = crc_inv[23:16];
            4'd3:    eng_byte = crc_inv[15:8];
            4'd4:    eng_byte = crc_inv[7:0];
            default: eng_byte = 8'h00;
         endcase
      end
   end

   // Next state of the frame, the engine and the result register.
   always_comb begin
      payload_crc_in = payload_crc_ff;
      remaining_in   = remaining_ff;
      frame_open_in  = frame_open_ff;
      busy_in        = busy_ff;
      kind_in        = kind_ff;
      idx_in         = idx_ff;
      last_in        = last_ff;
      close_in       = close_ff;
      hdr_in         = hdr_ff;
      crc_in         = crc_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;

      // Move one byte into the result register.
      if (advance) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.frame_byte   = eng_byte;
         rsp_data_in.last_of_run  = (idx_ff == last_ff);
         rsp_data_in.end_of_frame = close_ff && (idx_ff == last_ff);
         idx_in                   = idx_ff + 4'd1;
         if (kind_ff == KIND_HEADER && !idx_ff[3]) begin
            crc_in = dpf_pkg::crc32_byte(crc_ff, eng_byte);
         end
         if (run_done) begin
            busy_in = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Take a new item; the engine is free or finishing this cycle.
      if (accept) begin
         if (req_data.func == dpf_pkg::FUNC_START) begin
            payload_crc_in = dpf_pkg::CRC_PRESET;
            remaining_in   = len_sat;
            frame_open_in  = (len_sat != 10'd0);
            busy_in        = 1'b1;
            kind_in        = KIND_HEADER;
            idx_in         = 4'd0;
            last_in        = (len_sat == 10'd0) ? LAST_HEADER_EMPTY : LAST_HEADER;
            close_in       = (len_sat == 10'd0);
            hdr_in[0]      = {3'b010, req_data.window};
            hdr_in[1]      = {6'd0, len_sat[9:8]};
            hdr_in[2]      = len_sat[7:0];
            hdr_in[3]      = req_data.sequence_number;
            crc_in         = dpf_pkg::CRC_PRESET;
         end else if (payload_ok) begin
            remaining_in = rem_dec;
            busy_in      = 1'b1;
            kind_in      = KIND_PAYLOAD;
            idx_in       = 4'd0;
            hdr_in[0]    = req_data.data_byte;
            crc_in       = byte_crc;
            if (rem_dec == 10'd0) begin
               last_in        = LAST_PAYLOAD_CRC;
               close_in       = 1'b1;
               frame_open_in  = 1'b0;
               payload_crc_in = dpf_pkg::CRC_PRESET;
            end else begin
               last_in        = LAST_PAYLOAD;
               close_in       = 1'b0;
               payload_crc_in = byte_crc;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         payload_crc_ff <= dpf_pkg::CRC_PRESET;
         remaining_ff   <= 10'd0;
         frame_open_ff  <= 1'b0;
         busy_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         payload_crc_ff <= payload_crc_in;
         remaining_ff   <= remaining_in;
         frame_open_ff  <= frame_open_in;
         busy_ff        <= busy_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      idx_ff      <= idx_in;
      last_ff     <= last_in;
      close_ff    <= close_in;
      hdr_ff      <= hdr_in;
      crc_ff      <= crc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "assert_macros.svh"

   `DPF_ASSERT(a_eof_ends_run,
      rsp_valid_ff && rsp_data_ff.end_of_frame |-> rsp_data_ff.last_of_run,
      "end of frame on a byte that does not end its run")
   `DPF_ASSERT(a_open_has_bytes, frame_open_ff |-> remaining_ff != 10'd0,
      "open frame with no payload bytes expected")
   `DPF_ASSERT(a_idx_in_run, busy_ff |-> idx_ff <= last_ff,
      "engine index ran past the end of its run")
   `DPF_ASSERT_ALWAYS(a_reset_empty, reset |=> !busy_ff && !rsp_valid_ff,
      "engine or result register busy after reset")

endmodule
